// File: hw/rtl/sdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdc_pkg;

  localparam int FRAC = 16;
  localparam int QW   = FRAC + 1;
  localparam int DW   = 6;
  localparam int IW   = 3;
  localparam int MW   = 20;
  localparam int PW   = 2 * MW;

  localparam logic [QW-1:0] ONE_Q  = QW'(1) << FRAC;
  localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC - 1);

  localparam logic [DW-1:0] MIN_DEPTH   = DW'(2);
  localparam logic [DW-1:0] DEPTH_LIMIT = DW'(32);

  // divide by ten: (t * ceil(2^23 / 10)) >> 23, exact for t below 2^22
  localparam logic [MW-1:0] RECIP10   = MW'(838861);
  localparam int            DIV_SHIFT = 23;
  localparam logic [MW-1:0] RND10     = MW'(5);

  localparam logic [DW-1:0] MAX_DEPTH_RST  = DW'(12);
  localparam logic [QW-1:0] RAISE_THR_RST  = QW'(55706);
  localparam logic [QW-1:0] LOWER_THR_RST  = QW'(42598);
  localparam logic [QW-1:0] VAR_LIMIT_RST  = QW'(655);
  localparam logic [QW-1:0] ENT_LIMIT_RST  = QW'(22938);
  localparam logic [QW-1:0] SPIKE_DELTA_RST = QW'(6554);

  typedef enum logic [IW-1:0] {
    REG_MAX_DEPTH   = 3'd0,
    REG_RAISE_THR   = 3'd1,
    REG_LOWER_THR   = 3'd2,
    REG_VAR_LIMIT   = 3'd3,
    REG_ENT_LIMIT   = 3'd4,
    REG_SPIKE_DELTA = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_MEAN,
    S_MSQ,
    S_MM,
    S_FIN
  } state_e;

endpackage

`default_nettype wire

// File: hw/rtl/sdc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sdc_in_if import sdc_pkg::*; ();
  logic          valid;
  logic          ready;
  logic          mode;
  logic [QW-1:0] accept;
  logic          entropy_valid;
  logic [QW-1:0] entropy;

  modport source (output valid, mode, accept, entropy_valid, entropy, input ready);
  modport sink (input valid, mode, accept, entropy_valid, entropy, output ready);
endinterface

interface sdc_out_if import sdc_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [DW-1:0] depth;
  logic [QW-1:0] variance;
  logic [QW-1:0] entropy_used;
  logic          spike;

  modport source (output valid, depth, variance, entropy_used, spike, input ready);
  modport sink (input valid, depth, variance, entropy_used, spike, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sdc_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module sdc_mul import sdc_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic [MW-1:0] a_i,
  input  wire logic [MW-1:0] b_i,
  output logic      [PW-1:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

`default_nettype wire

// File: hw/rtl/speculative_depth_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Speculative depth controller.
// Input channel in_i carries one control step per beat: mode (0 = step,
// 1 = restart), accept and an optional entropy, both Q16. Output channel
// out_o returns one beat per input beat: new depth, variance estimate,
// entropy used and a spike flag. Thresholds and the depth limit are set
// through the cfg write port; the user must write them only while the block
// is idle, which the block itself does not enforce. A control step runs on
// one shared registered 20x20 multiplier that is used four times in turn
// (accept squared, two divides by ten, mean squared) in the states SQ, MEAN,
// MSQ and MM, then decides in FIN and registers the result at the output.
// A restart beat goes from idle straight to FIN. in_i.ready is high only
// while the sequencer is idle, so no new beat is taken before FIN is left.
// The result sits in an output register; the next step may be accepted while
// it waits, and a stalled receiver holds the sequencer in its last step.
// Reset clears all history, sets depth to 2 and loads the default registers.
module speculative_depth_controller_top import sdc_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [IW-1:0] cfg_idx_i,
  input  wire logic [QW-1:0] cfg_data_i,
  sdc_in_if.sink             in_i,
  sdc_out_if.source          out_o
);

  state_e state_q, state_d;

  logic [DW-1:0] max_depth_q;
  logic [QW-1:0] raise_thr_q, lower_thr_q, var_limit_q, ent_limit_q, spike_delta_q;

  logic          mode_q, ev_q;
  logic [QW-1:0] a_q, ein_q, sq_q;
  logic [QW-1:0] mean_q, msq_q, last_ent_q;
  logic          have_acc_q, have_ent_q;
  logic [DW-1:0] depth_q;

  logic          out_valid_q;
  logic [DW-1:0] out_depth_q;
  logic [QW-1:0] out_var_q, out_ent_q;
  logic          out_spike_q;

  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;
  logic [MW-1:0] t_mean, t_msq;
  logic [QW-1:0] div_res, rnd_res;
  logic [QW-1:0] var_val, e_val;
  logic          spike_val, fin_go, in_ready;
  logic [DW-1:0] maxd, dcur, dnew;

  sdc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign t_mean  = (MW'(mean_q) << 3) + MW'(mean_q) + MW'(a_q) + RND10;
  assign t_msq   = (MW'(msq_q) << 3) + MW'(msq_q) + MW'(sq_q) + RND10;
  assign div_res = QW'(prod >> DIV_SHIFT);
  assign rnd_res = QW'((prod + HALF_P) >> FRAC);
  assign fin_go  = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) state_d = in_i.mode ? S_FIN : S_SQ;
      end
      S_SQ:   state_d = S_MEAN;
      S_MEAN: state_d = S_MSQ;
      S_MSQ:  state_d = S_MM;
      S_MM:   state_d = S_FIN;
      S_FIN: begin
        if (fin_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands and input ready
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    in_ready = 1'b0;
    case (state_q)
      S_IDLE: in_ready = 1'b1;
      S_SQ: begin
        mul_a = MW'(a_q);
        mul_b = MW'(a_q);
      end
      S_MEAN: begin
        mul_a = t_mean;
        mul_b = RECIP10;
      end
      S_MSQ: begin
        mul_a = t_msq;
        mul_b = RECIP10;
      end
      // mean squared stays in the product while the result waits
      S_MM, S_FIN: begin
        mul_a = MW'(mean_q);
        mul_b = MW'(mean_q);
      end
      default: ;
    endcase
  end

  // final step decision
  always_comb begin
    var_val = (msq_q > rnd_res) ? msq_q - rnd_res : '0;
    if (ev_q) e_val = (ein_q > ONE_Q) ? ONE_Q : ein_q;
    else      e_val = ONE_Q - a_q;
    spike_val = have_ent_q
             && ({1'b0, e_val} > ({1'b0, last_ent_q} + {1'b0, spike_delta_q}))
             && (e_val > ent_limit_q);
    maxd = max_depth_q;
    if (maxd < MIN_DEPTH)   maxd = MIN_DEPTH;
    if (maxd > DEPTH_LIMIT) maxd = DEPTH_LIMIT;
    dcur = (depth_q < MIN_DEPTH) ? MIN_DEPTH : depth_q;
    dnew = dcur;
    if ((a_q < lower_thr_q) || spike_val) begin
      if (dcur > MIN_DEPTH) dnew = dcur - DW'(1);
    end else if ((a_q > raise_thr_q) && (var_val < var_limit_q) && (e_val < ent_limit_q)) begin
      dnew = dcur + DW'(1);
    end
    if (dnew > maxd)      dnew = maxd;
    if (dnew < MIN_DEPTH) dnew = MIN_DEPTH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_depth_q   <= MAX_DEPTH_RST;
      raise_thr_q   <= RAISE_THR_RST;
      lower_thr_q   <= LOWER_THR_RST;
      var_limit_q   <= VAR_LIMIT_RST;
      ent_limit_q   <= ENT_LIMIT_RST;
      spike_delta_q <= SPIKE_DELTA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_DEPTH:   max_depth_q   <= cfg_data_i[DW-1:0];
        REG_RAISE_THR:   raise_thr_q   <= cfg_data_i;
        REG_LOWER_THR:   lower_thr_q   <= cfg_data_i;
        REG_VAR_LIMIT:   var_limit_q   <= cfg_data_i;
        REG_ENT_LIMIT:   ent_limit_q   <= cfg_data_i;
        REG_SPIKE_DELTA: spike_delta_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      have_acc_q  <= 1'b0;
      have_ent_q  <= 1'b0;
      mean_q      <= '0;
      msq_q       <= '0;
      last_ent_q  <= '0;
      depth_q     <= MIN_DEPTH;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_go)           out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_MSQ: mean_q <= have_acc_q ? div_res : a_q;
        S_MM:  msq_q  <= have_acc_q ? div_res : sq_q;
        S_FIN: begin
          if (fin_go) begin
            if (mode_q) begin
              have_acc_q <= 1'b0;
              have_ent_q <= 1'b0;
              mean_q     <= '0;
              msq_q      <= '0;
              last_ent_q <= '0;
              depth_q    <= MIN_DEPTH;
            end else begin
              have_acc_q <= 1'b1;
              have_ent_q <= 1'b1;
              last_ent_q <= e_val;
              depth_q    <= dnew;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      mode_q <= in_i.mode;
      a_q    <= (in_i.accept > ONE_Q) ? ONE_Q : in_i.accept;
      ev_q   <= in_i.entropy_valid;
      ein_q  <= in_i.entropy;
    end
    if (state_q == S_MEAN) sq_q <= rnd_res;
    if (fin_go) begin
      out_depth_q <= mode_q ? MIN_DEPTH : dnew;
      out_var_q   <= mode_q ? '0 : var_val;
      out_ent_q   <= mode_q ? '0 : e_val;
      out_spike_q <= mode_q ? 1'b0 : spike_val;
    end
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.depth        = out_depth_q;
  assign out_o.variance     = out_var_q;
  assign out_o.entropy_used = out_ent_q;
  assign out_o.spike        = out_spike_q;

  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_q >= MIN_DEPTH) && (depth_q <= DEPTH_LIMIT))
    else $error("depth state out of range");

  a_out_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_depth_q >= MIN_DEPTH) && (out_depth_q <= DEPTH_LIMIT))
    else $error("output depth out of range");

  a_fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_q && (state_q == S_IDLE))
    else $error("finished step not presented");

  a_spike_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_spike_q) |-> have_ent_q)
    else $error("spike without entropy history");

endmodule

`default_nettype wire
